### src/voc_pkg.sv
// voc_pkg: command codes and payload types for the voxel occupancy chunk
// no dependencies; imported by every module of the block
package voc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned OccW   = 2;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [OccW-1:0] OccMax = 2'd3;
  localparam logic [OccW-1:0] OccInsertStep = 2'd2;

  localparam logic [CmdW-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CmdW-1:0] CMD_DELETE     = 3'd1;
  localparam logic [CmdW-1:0] CMD_LOOKUP_OCC = 3'd2;
  localparam logic [CmdW-1:0] CMD_SET_INFL   = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLR_INFL   = 3'd4;
  localparam logic [CmdW-1:0] CMD_LOOKUP_INF = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic [OccW-1:0] occupancy;
    logic            inflated;
    logic            out_of_range;
    logic            changed;
  } res_t;

endpackage

### src/voc_locate.sv
// voc_locate: turns a world position into a voxel index relative to the chunk origin
// depends on voc_pkg
module voc_locate #(
  parameter int unsigned EDGE_LEN = 16
) (
  input  logic signed [voc_pkg::CoordW-1:0]     pos_x,
  input  logic signed [voc_pkg::CoordW-1:0]     pos_y,
  input  logic signed [voc_pkg::CoordW-1:0]     pos_z,
  input  logic signed [voc_pkg::CoordW-1:0]     origin_x,
  input  logic signed [voc_pkg::CoordW-1:0]     origin_y,
  input  logic signed [voc_pkg::CoordW-1:0]     origin_z,
  output logic [$clog2(EDGE_LEN**3)-1:0]        idx,
  output logic                                  out_of_range
);
  import voc_pkg::*;

  localparam int unsigned AxW  = $clog2(EDGE_LEN);
  localparam int unsigned IdxW = $clog2(EDGE_LEN**3);

  logic signed [CoordW:0] rel_x, rel_y, rel_z;
  logic in_x, in_y, in_z;

  // exact difference over one extra bit, no wrap
  always_comb begin
    rel_x = {pos_x[CoordW-1], pos_x} - {origin_x[CoordW-1], origin_x};
    rel_y = {pos_y[CoordW-1], pos_y} - {origin_y[CoordW-1], origin_y};
    rel_z = {pos_z[CoordW-1], pos_z} - {origin_z[CoordW-1], origin_z};
    in_x = !rel_x[CoordW] && (rel_x[CoordW-1:0] < CoordW'(EDGE_LEN));
    in_y = !rel_y[CoordW] && (rel_y[CoordW-1:0] < CoordW'(EDGE_LEN));
    in_z = !rel_z[CoordW] && (rel_z[CoordW-1:0] < CoordW'(EDGE_LEN));
    out_of_range = !(in_x && in_y && in_z);
    idx = IdxW'(rel_z[AxW-1:0]) * IdxW'(EDGE_LEN * EDGE_LEN)
        + IdxW'(rel_y[AxW-1:0]) * IdxW'(EDGE_LEN)
        + IdxW'(rel_x[AxW-1:0]);
  end

endmodule

### src/voxel_occupancy_chunk.sv
// voxel_occupancy_chunk: top level, command pipeline and voxel store
// depends on voc_pkg and voc_locate
//
// Usage
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. Each item carries a command code and a world position; it produces
//   exactly one result, shown on result for one cycle with done high.
//   Results cannot be held off by the receiver.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data
//   sets the chunk origin (index 0 x, 1 y, 2 z). cfg_ready is always high;
//   other indexes are ignored. Write it only while no command is in flight.
//   Pipeline: the position register loads at the accepting edge, then the
//   store is read, then the result register loads and done rises with it.
//   Throughput: one command per cycle while busy is low; a read-modify-write
//   on the same voxel in back-to-back commands is served by a bypass from
//   the last write.
//   Reset: rst clears the control state, then a clearing pass writes zero to
//   all EDGE_LEN**3 entries of the store, one per cycle; busy stays high
//   throughout and no command is taken.
module voxel_occupancy_chunk #(
  parameter int unsigned EDGE_LEN = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  voc_pkg::cmd_t                        item,
  output logic                                 done,
  output voc_pkg::res_t                        result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [voc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [voc_pkg::CoordW-1:0]           cfg_data
);
  import voc_pkg::*;

  localparam int unsigned Depth = EDGE_LEN**3;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned EntW  = OccW + 1;

  logic signed [CoordW-1:0] origin_x, origin_y, origin_z;

  // clearing pass
  logic            clearing;
  logic [IdxW-1:0] clr_addr;

  // position stage
  logic            a_valid;
  cmd_t            a_cmd;
  logic [IdxW-1:0] a_idx;
  logic            a_oor;

  // update stage
  logic            b_valid;
  logic [CmdW-1:0] b_cmd;
  logic [IdxW-1:0] b_idx;
  logic            b_oor;
  logic [EntW-1:0] rdata;

  // last write, for back-to-back updates of the same voxel
  logic            fwd_valid;
  logic [IdxW-1:0] fwd_idx;
  logic [EntW-1:0] fwd_data;

  logic [EntW-1:0] mem [Depth];

  logic [OccW-1:0] occ_cur, occ_new;
  logic            infl_cur, infl_new;
  logic            flag, flag_next;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  assign busy = clearing;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  voc_locate #(
    .EDGE_LEN(EDGE_LEN)
  ) u_locate (
    .pos_x       (a_cmd.pos_x),
    .pos_y       (a_cmd.pos_y),
    .pos_z       (a_cmd.pos_z),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .idx         (a_idx),
    .out_of_range(a_oor)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      flag      <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == IdxW'(Depth - 1)) begin
          clearing <= 1'b0;
        end
      end
      a_valid   <= start && !busy;
      b_valid   <= a_valid;
      fwd_valid <= wr_en && !clearing;
      flag      <= flag_next;
      done      <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_cmd <= item;
    end
    b_cmd    <= a_cmd.cmd;
    b_idx    <= a_idx;
    b_oor    <= a_oor;
    fwd_idx  <= wr_addr;
    fwd_data <= wr_data;
    result.occupancy    <= b_oor ? '0 : occ_new;
    result.inflated     <= b_oor ? 1'b0 : infl_new;
    result.out_of_range <= b_oor;
    result.changed      <= flag_next;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[a_idx];
  end

  always_comb begin
    if (fwd_valid && (fwd_idx == b_idx)) begin
      {occ_cur, infl_cur} = fwd_data;
    end else begin
      {occ_cur, infl_cur} = rdata;
    end
    occ_new  = occ_cur;
    infl_new = infl_cur;
    case (b_cmd)
      CMD_INSERT: begin
        occ_new = (occ_cur == '0) ? OccInsertStep : OccMax;
      end
      CMD_DELETE: begin
        if (occ_cur != '0) begin
          occ_new = occ_cur - 1'b1;
        end
      end
      CMD_SET_INFL:   infl_new = 1'b1;
      CMD_CLR_INFL:   infl_new = 1'b0;
      CMD_LOOKUP_OCC: ;
      CMD_LOOKUP_INF: ;
      default: ;
    endcase
    flag_next = flag || (b_valid && !b_oor && (occ_new != occ_cur));
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = b_valid && !b_oor;
      wr_addr = b_idx;
      wr_data = {occ_new, infl_new};
    end
  end

endmodule

### src/voc_checker.sv
// voc_checker: port-level checks on the voxel occupancy chunk
// depends on voc_pkg; bound to voxel_occupancy_chunk below
module voc_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input voc_pkg::res_t result
);
  import voc_pkg::*;

  // every accepted command yields a result with done high, through the position, update and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted command produced no result");

  // no result without a command accepted before it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching command");

  // nothing is in flight during the clearing pass
  a_quiet_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result while clearing the store");

  // a position outside the chunk reports empty fields
  a_oor_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_of_range) |-> (result.occupancy == '0 && !result.inflated))
    else $error("out-of-range result carries voxel data");

endmodule

bind voxel_occupancy_chunk voc_checker u_voc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
